// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define ASSERT_CLK_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_CLK_NR(label, clk, prop)
`endif
`endif

// ===== rtl/core/gms_pkg.sv =====
// ----------------------------------------------------------------------------
// gms_pkg
// Command codes, matrix selects and fixed-point constants of the matrix stack.
// ----------------------------------------------------------------------------
package gms_pkg;
  localparam int MatrixWords   = 16;
  localparam int PosStackDepth = 32;

  typedef enum logic [2:0] {
    CMD_MODE     = 3'd0,
    CMD_PUSH     = 3'd1,
    CMD_POP      = 3'd2,
    CMD_STORE    = 3'd3,
    CMD_RESTORE  = 3'd4,
    CMD_IDENTITY = 3'd5,
    CMD_LOAD44   = 3'd6,
    CMD_LOAD43   = 3'd7
  } cmd_t;

  localparam logic [1:0] SEL_PROJ = 2'd0;
  localparam logic [1:0] SEL_POS  = 2'd1;
  localparam logic [1:0] SEL_VEC  = 2'd2;
  localparam logic [1:0] SEL_TEX  = 2'd3;

  localparam logic [31:0] FX_ONE = 32'h0000_1000;
  localparam logic [5:0]  POS_LIMIT = 6'd30;
endpackage

// ===== rtl/core/geometry_matrix_stack_top.sv =====
// ----------------------------------------------------------------------------
// geometry_matrix_stack_top
// Matrix stack of a geometry engine: mode, push, pop, store, restore,
// identity and gathered 4x4 / 4x3 loads, with one read-back word per request.
// ----------------------------------------------------------------------------
// A request is taken at a clock edge with start high and busy low; busy rises
// the next cycle and stays high until the result strobe. The result is shown
// for one cycle with done high; the receiver cannot hold it off.
// Current matrices live in one 64-word memory, the one-deep projection and
// texture stacks and the buffered load words in a second memory, and the
// position/vector stack in a third; each has one port, read data registered.
// Mode and non-committing load words pass through decode, read-back and the
// result state; push, pop, store, restore, identity and a committing load
// first copy word by word through the single-port memories, reading and then
// writing each word: one matrix, or two when both position and vector are written.
// The next request is taken at the edge that ends the done cycle, so a new
// request waits until the copy loop over the memory is through.
// Reset clears the pointers, mode, load count and error flag; memory contents
// are undefined until written.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module geometry_matrix_stack_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  input  logic [2:0]         mode,
  input  logic [31:0]        param,
  input  logic [1:0]         read_select,
  input  logic [3:0]         read_index,
  output logic signed [31:0] read_word,
  output logic               stack_error,
  output logic               proj_level,
  output logic               tex_level,
  output logic [5:0]         pos_level,
  output logic [1:0]         current_mode,
  output logic               clip_changed,
  output logic               load_committed
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_DECODE, ST_RD, ST_WR, ST_READBACK, ST_RESULT
  } state_t;

  // copy source/destination kinds
  typedef enum logic [1:0] {
    SRC_CUR, SRC_AUX, SRC_STK, SRC_GEN
  } src_t;

  state_t state;
  logic [31:0] cur_mem [64];
  logic [31:0] aux_mem [48];  // 0..15 proj stack, 16..31 tex stack, 32..47 load buffer
  logic [31:0] stk_mem [1024];

  logic [2:0]  cmd;
  logic [31:0] prm;
  logic [1:0]  rsel;
  logic [3:0]  ridx;
  logic [4:0]  param_count;
  logic [5:0]  pos_pointer;
  logic        proj_pointer, tex_pointer, error_flag;
  logic [1:0]  mode_reg;
  logic        clip, committed;

  // copy job: up to two passes of 16 words
  src_t        src, dst;
  logic [1:0]  src_mat, dst_mat;     // matrix select for cur / aux
  logic [4:0]  slot;
  logic        pass2;                // second pass (vector matrix) pending
  logic        pass;                 // current pass index for stack half
  logic        is43;
  logic [3:0]  widx;

  logic [31:0] cur_q, aux_q, stk_q;
  logic [31:0] gen_word;

  // 4x3 source index: row*3+col
  logic [1:0] wr_row, wr_col;
  logic [3:0] src_idx;
  assign wr_row = widx[3:2];
  assign wr_col = widx[1:0];
  always_comb begin
    if (src == SRC_GEN && is43)
      src_idx = 4'({2'b00, wr_row} * 4'd3 + {2'b00, wr_col});
    else
      src_idx = widx;
  end

  // identity / 4x3 fixed column word
  always_comb begin
    gen_word = 32'd0;
    if (!is43) begin
      if (wr_row == wr_col) gen_word = gms_pkg::FX_ONE;
    end else if (wr_col == 2'd3 && wr_row == 2'd3) begin
      gen_word = gms_pkg::FX_ONE;
    end
  end

  logic        gen_from_buf;
  assign gen_from_buf = committed && !(is43 && wr_col == 2'd3);

  logic [31:0] wdata;
  always_comb begin
    unique case (src)
      SRC_CUR: wdata = cur_q;
      SRC_AUX: wdata = aux_q;
      SRC_STK: wdata = stk_q;
      default: wdata = gen_from_buf ? aux_q : gen_word;
    endcase
  end

  logic [5:0]  aux_rd_base;
  assign aux_rd_base = (src == SRC_GEN) ? 6'd32 : {1'b0, src_mat[0], 4'd0};

  // memory ports
  logic        cur_we, aux_we, stk_we;
  logic [5:0]  cur_addr, aux_addr;
  logic [9:0]  stk_addr;
  logic [31:0] cur_wd, aux_wd, stk_wd;

  always_comb begin
    cur_we = 1'b0; aux_we = 1'b0; stk_we = 1'b0;
    cur_wd = wdata; aux_wd = wdata; stk_wd = wdata;
    cur_addr = {src_mat, widx};
    aux_addr = aux_rd_base + {2'b00, src_idx};
    stk_addr = {slot, pass, widx};
    unique case (state)
      ST_DECODE: begin
        // buffer the load word
        if (cmd == gms_pkg::CMD_LOAD44 || cmd == gms_pkg::CMD_LOAD43) begin
          aux_we = 1'b1;
          aux_addr = 6'd32 + {2'b00, param_count[3:0]};
          aux_wd = prm;
        end
      end
      ST_WR: begin
        unique case (dst)
          SRC_CUR: begin cur_we = 1'b1; cur_addr = {dst_mat, widx}; end
          SRC_AUX: begin aux_we = 1'b1; aux_addr = {1'b0, dst_mat[0], widx}; end
          default: stk_we = 1'b1;
        endcase
      end
      ST_READBACK: cur_addr = {rsel, ridx};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cur_we) cur_mem[cur_addr] <= cur_wd;
    cur_q <= cur_mem[cur_addr];
  end
  always_ff @(posedge clk) begin
    if (aux_we) aux_mem[aux_addr] <= aux_wd;
    aux_q <= aux_mem[aux_addr];
  end
  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_addr] <= stk_wd;
    stk_q <= stk_mem[stk_addr];
  end

  logic is_pt;
  logic [5:0] pos_pop;
  logic [4:0] count_inc;
  assign is_pt = (mode_reg == gms_pkg::SEL_PROJ) || (mode_reg == gms_pkg::SEL_TEX);
  assign pos_pop = pos_pointer - prm[5:0];
  assign count_inc = param_count + 5'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      busy <= 1'b0;
      done <= 1'b0;
      param_count <= '0;
      pos_pointer <= '0;
      proj_pointer <= 1'b0;
      tex_pointer <= 1'b0;
      mode_reg <= gms_pkg::SEL_PROJ;
      error_flag <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            cmd <= mode; prm <= param; rsel <= read_select; ridx <= read_index;
            busy <= 1'b1;
            state <= ST_DECODE;
          end
        end
        ST_DECODE: begin
          clip <= 1'b0; committed <= 1'b0;
          widx <= '0; pass <= 1'b0; pass2 <= 1'b0; is43 <= 1'b0;
          src_mat <= mode_reg; dst_mat <= mode_reg;
          state <= ST_RD;
          unique case (cmd)
            gms_pkg::CMD_MODE: begin
              mode_reg <= prm[1:0];
              state <= ST_READBACK;
            end
            gms_pkg::CMD_PUSH, gms_pkg::CMD_STORE: begin
              if (is_pt) begin
                src <= SRC_CUR; dst <= SRC_AUX;
                if (cmd == gms_pkg::CMD_PUSH) begin
                  if (mode_reg == gms_pkg::SEL_TEX) begin
                    if (tex_pointer) error_flag <= 1'b1;
                    tex_pointer <= ~tex_pointer;
                  end else begin
                    if (proj_pointer) error_flag <= 1'b1;
                    proj_pointer <= ~proj_pointer;
                  end
                end
              end else begin
                src <= SRC_CUR; dst <= SRC_STK;
                src_mat <= gms_pkg::SEL_POS; pass2 <= 1'b1;
                if (cmd == gms_pkg::CMD_PUSH) begin
                  slot <= pos_pointer[4:0];
                  if (pos_pointer > gms_pkg::POS_LIMIT) error_flag <= 1'b1;
                  pos_pointer <= pos_pointer + 6'd1;
                end else begin
                  slot <= prm[4:0];
                  if ({1'b0, prm[4:0]} > gms_pkg::POS_LIMIT) error_flag <= 1'b1;
                end
              end
            end
            gms_pkg::CMD_POP, gms_pkg::CMD_RESTORE: begin
              if (is_pt) begin
                src <= SRC_AUX; dst <= SRC_CUR;
                clip <= (mode_reg == gms_pkg::SEL_PROJ);
                if (cmd == gms_pkg::CMD_POP) begin
                  if (mode_reg == gms_pkg::SEL_TEX) begin
                    if (!tex_pointer) error_flag <= 1'b1;
                    tex_pointer <= ~tex_pointer;
                  end else begin
                    if (!proj_pointer) error_flag <= 1'b1;
                    proj_pointer <= ~proj_pointer;
                  end
                end
              end else begin
                src <= SRC_STK; dst <= SRC_CUR;
                dst_mat <= gms_pkg::SEL_POS; pass2 <= 1'b1; clip <= 1'b1;
                if (cmd == gms_pkg::CMD_POP) begin
                  slot <= pos_pop[4:0];
                  pos_pointer <= pos_pop;
                  if (pos_pop > gms_pkg::POS_LIMIT) error_flag <= 1'b1;
                end else begin
                  slot <= prm[4:0];
                  if ({1'b0, prm[4:0]} > gms_pkg::POS_LIMIT) error_flag <= 1'b1;
                end
              end
            end
            gms_pkg::CMD_IDENTITY: begin
              src <= SRC_GEN; dst <= SRC_CUR;
              clip <= (mode_reg != gms_pkg::SEL_TEX);
              if (!is_pt) begin
                dst_mat <= gms_pkg::SEL_POS;
                pass2 <= (mode_reg == gms_pkg::SEL_VEC);
              end
            end
            default: begin
              // load word: already written to the buffer this cycle
              if (count_inc >= ((cmd == gms_pkg::CMD_LOAD43) ? 5'd12 : 5'd16)) begin
                param_count <= '0;
                committed <= 1'b1;
                is43 <= (cmd == gms_pkg::CMD_LOAD43);
                src <= SRC_GEN; dst <= SRC_CUR;
                clip <= (mode_reg != gms_pkg::SEL_TEX);
                if (!is_pt) begin
                  dst_mat <= gms_pkg::SEL_POS;
                  pass2 <= (mode_reg == gms_pkg::SEL_VEC);
                end
              end else begin
                param_count <= count_inc;
                state <= ST_READBACK;
              end
            end
          endcase
        end
        ST_RD: state <= ST_WR;
        ST_WR: begin
          widx <= widx + 4'd1;
          state <= ST_RD;
          if (widx == 4'(gms_pkg::MatrixWords - 1)) begin
            if (pass2) begin
              pass2 <= 1'b0;
              pass <= 1'b1;
              if (src == SRC_CUR) src_mat <= gms_pkg::SEL_VEC;
              if (dst == SRC_CUR) dst_mat <= gms_pkg::SEL_VEC;
            end else begin
              state <= ST_READBACK;
            end
          end
        end
        ST_READBACK: state <= ST_RESULT;
        ST_RESULT: begin
          read_word <= cur_q;
          stack_error <= error_flag;
          proj_level <= proj_pointer;
          tex_level <= tex_pointer;
          pos_level <= pos_pointer;
          current_mode <= mode_reg;
          clip_changed <= clip;
          load_committed <= committed;
          done <= 1'b1;
          busy <= 1'b0;
          state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_CLK(a_done_one_cycle, clk, rst, done |=> !done)
  `ASSERT_CLK(a_done_ends_busy, clk, rst, done |-> !busy)
  `ASSERT_CLK(a_count_range, clk, rst, param_count < 5'd16)
  `ASSERT_CLK(a_commit_clears, clk, rst, (done && load_committed) |-> param_count == 5'd0)

endmodule
